/* hdl/nchs_pkg.sv */
// nchs_pkg: shared types and constants for the nearest cluster head search block
// beat structs for the request and response channels, request codes, register reset
// no dependencies

package nchs_pkg;

	// fixed field widths of the channel beats
	typedef logic [0:0]  req_code_t;
	typedef logic [6:0]  idx_t;
	typedef logic [9:0]  coord_t;
	typedef logic [20:0] dist_t;
	typedef logic [21:0] limit_t;

	// request codes
	localparam req_code_t REQ_WRITE = 1'b0;
	localparam req_code_t REQ_QUERY = 1'b1;

	// search limit after reset
	localparam limit_t LIMIT_RESET = 22'd1000000;

	// request beat
	typedef struct packed {
		req_code_t req_type;
		idx_t      node_index;
		coord_t    pos_x;
		coord_t    pos_y;
		logic      alive_in;
		logic      head_in;
	} req_t;

	// response beat
	typedef struct packed {
		logic  head_found;
		idx_t  head_index;
		dist_t distance_sq;
	} rsp_t;

endpackage

/* hdl/nearest_cluster_head_search_core.sv */
// nearest_cluster_head_search_core: node table and nearest cluster head query engine
// depends on nchs_pkg (beat types, codes) and nchs_dist (distance pipeline)

// A write beat fills one node entry and gives no response; a write to an index
// beyond the table is dropped. A query beat gives one response: a dead node, the
// base station or an index beyond the table answers "none found", a head node answers
// itself at distance 0, any other node gets the nearest alive head of entries 1 and up
// (lowest index on a tie) strictly below search_limit. The node table is one
// synchronous memory with a registered read port; a scanning query reads it one entry
// per cycle: the own entry is read in the accept cycle, then entries 1 to NODE_COUNT-1,
// then the distance pipeline drains and the response loads once the output register is
// free. After reset a clearing pass over all NODE_COUNT entries zeroes the alive and
// head marks; no request is accepted during that pass.
// A new request is accepted while an earlier response still waits in the output register.

module nearest_cluster_head_search_core #(
	parameter int NODE_COUNT = 128,
	parameter int COORD_BITS = 10
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_ready,
	input  nchs_pkg::req_t        req,
	output logic                  rsp_valid,
	input  logic                  rsp_ready,
	output nchs_pkg::rsp_t        rsp,
	input  logic                  cfg_we,
	input  nchs_pkg::limit_t      cfg_wdata
);

	localparam int IDX_W = (NODE_COUNT > 2) ? $clog2(NODE_COUNT) : 1;
	localparam int CB    = COORD_BITS;
	localparam int D_W   = 2 * CB + 1;
	localparam int M_W   = (D_W > 22) ? D_W : 22;
	localparam int E_W   = 2 * CB + 2;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NODE_COUNT - 1);
	localparam logic [IDX_W-1:0] FIRST_IDX = IDX_W'(1);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SELF,
		ST_SCAN,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	state_t state_q;

	// node table: {x, y, alive, head}
	logic [E_W-1:0]   mem [NODE_COUNT];
	logic [E_W-1:0]   rd_data_q;
	logic             mem_we;
	logic [IDX_W-1:0] mem_waddr;
	logic [E_W-1:0]   mem_wdata;
	logic [IDX_W-1:0] rd_addr;

	nchs_pkg::limit_t search_limit_q;
	logic [IDX_W-1:0] scan_q;
	logic [IDX_W-1:0] qidx_q;
	logic [CB-1:0]    own_x_q;
	logic [CB-1:0]    own_y_q;
	logic             iss_s1;
	logic [IDX_W-1:0] idx_s1;

	logic             found_q;
	logic [IDX_W-1:0] best_idx_q;
	logic [D_W-1:0]   best_d_q;
	logic [M_W-1:0]   min_q;

	logic             accept;
	logic             in_range;
	logic [CB-1:0]    rd_x;
	logic [CB-1:0]    rd_y;
	logic             rd_alive;
	logic             rd_head;
	logic             cand_s1;
	logic             vld_s2;
	logic             cand_s2;
	logic [IDX_W-1:0] idx_s2;
	logic [D_W-1:0]   dist_sum;
	logic             hit;
	logic             rsp_free;

	// handshake
	assign req_ready = (state_q == ST_IDLE);
	assign accept    = req_valid && req_ready;
	assign in_range  = (32'(req.node_index) < NODE_COUNT);
	assign rsp_free  = !rsp_valid || rsp_ready;

	// memory port selection
	always_comb begin
		mem_we    = (state_q == ST_CLEAR) ||
			(accept && (req.req_type == nchs_pkg::REQ_WRITE) && in_range);
		mem_waddr = (state_q == ST_CLEAR) ? scan_q : IDX_W'(req.node_index);
		mem_wdata = (state_q == ST_CLEAR) ? '0 :
			{CB'(req.pos_x), CB'(req.pos_y), req.alive_in, req.head_in};
		rd_addr   = (state_q == ST_IDLE) ? IDX_W'(req.node_index) : scan_q;
	end

	// table memory, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rd_data_q <= mem[rd_addr];
	end

	// read data fields
	assign rd_x     = rd_data_q[E_W-1 -: CB];
	assign rd_y     = rd_data_q[CB+1 -: CB];
	assign rd_alive = rd_data_q[1];
	assign rd_head  = rd_data_q[0];
	assign cand_s1  = rd_alive && rd_head && (idx_s1 != qidx_q);

	// distance pipeline
	nchs_dist #(
		.COORD_BITS (CB),
		.IDX_W      (IDX_W)
	) u_dist (
		.clk      (clk),
		.arst_n   (arst_n),
		.vld      (iss_s1),
		.cand     (cand_s1),
		.idx      (idx_s1),
		.own_x    (own_x_q),
		.own_y    (own_y_q),
		.ent_x    (rd_x),
		.ent_y    (rd_y),
		.vld_s2   (vld_s2),
		.cand_s2  (cand_s2),
		.idx_s2   (idx_s2),
		.dist_sum (dist_sum)
	);

	// candidate beats the running minimum
	assign hit = vld_s2 && cand_s2 && (M_W'(dist_sum) < min_q);

	// search limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			search_limit_q <= nchs_pkg::LIMIT_RESET;
		end else if (cfg_we) begin
			search_limit_q <= cfg_wdata;
		end
	end

	// sequencer, scan state and response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			scan_q     <= '0;
			qidx_q     <= '0;
			own_x_q    <= '0;
			own_y_q    <= '0;
			iss_s1     <= 1'b0;
			idx_s1     <= '0;
			found_q    <= 1'b0;
			best_idx_q <= '0;
			best_d_q   <= '0;
			min_q      <= '0;
			rsp_valid  <= 1'b0;
			rsp        <= '0;
		end else begin
			// a drained response frees the register unless a new one loads now
			if (rsp_valid && rsp_ready && (state_q != ST_FINISH)) begin
				rsp_valid <= 1'b0;
			end
			if (hit) begin
				found_q    <= 1'b1;
				best_idx_q <= idx_s2;
				best_d_q   <= dist_sum;
				min_q      <= M_W'(dist_sum);
			end
			case (state_q)
				ST_CLEAR: begin
					scan_q <= scan_q + 1'b1;
					if (scan_q == LAST_IDX) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept && (req.req_type == nchs_pkg::REQ_QUERY)) begin
						qidx_q     <= IDX_W'(req.node_index);
						scan_q     <= FIRST_IDX;
						found_q    <= 1'b0;
						best_idx_q <= '0;
						best_d_q   <= '0;
						min_q      <= M_W'(search_limit_q);
						if (!in_range || (req.node_index == '0)) begin
							state_q <= ST_FINISH;
						end else begin
							state_q <= ST_SELF;
						end
					end
				end
				ST_SELF: begin
					// own entry is in the read register, entry 1 is being read
					own_x_q <= rd_x;
					own_y_q <= rd_y;
					if (!rd_alive) begin
						state_q <= ST_FINISH;
					end else if (rd_head) begin
						found_q    <= 1'b1;
						best_idx_q <= qidx_q;
						state_q    <= ST_FINISH;
					end else begin
						iss_s1 <= 1'b1;
						idx_s1 <= FIRST_IDX;
						scan_q <= scan_q + 1'b1;
						state_q <= (FIRST_IDX == LAST_IDX) ? ST_DRAIN : ST_SCAN;
					end
				end
				ST_SCAN: begin
					iss_s1 <= 1'b1;
					idx_s1 <= scan_q;
					scan_q <= scan_q + 1'b1;
					if (scan_q == LAST_IDX) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					iss_s1 <= 1'b0;
					if (!iss_s1 && !vld_s2) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (rsp_free) begin
						rsp_valid            <= 1'b1;
						rsp.head_found       <= found_q;
						rsp.head_index       <= nchs_pkg::idx_t'(best_idx_q);
						rsp.distance_sq      <= nchs_pkg::dist_t'(best_d_q);
						state_q              <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

/* hdl/nchs_dist.sv */
// nchs_dist: squared euclidean distance pipeline for one table entry per cycle
// abs differences combinational, squares registered, sum on the output side
// no package dependencies

module nchs_dist #(
	parameter int COORD_BITS = 10,
	parameter int IDX_W      = 7
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    vld,
	input  logic                    cand,
	input  logic [IDX_W-1:0]        idx,
	input  logic [COORD_BITS-1:0]   own_x,
	input  logic [COORD_BITS-1:0]   own_y,
	input  logic [COORD_BITS-1:0]   ent_x,
	input  logic [COORD_BITS-1:0]   ent_y,
	output logic                    vld_s2,
	output logic                    cand_s2,
	output logic [IDX_W-1:0]        idx_s2,
	output logic [2*COORD_BITS:0]   dist_sum
);

	localparam int SQ_W = 2 * COORD_BITS;

	logic [COORD_BITS-1:0] dx;
	logic [COORD_BITS-1:0] dy;
	logic [SQ_W-1:0]       sq_x_s2;
	logic [SQ_W-1:0]       sq_y_s2;

	// absolute coordinate differences
	always_comb begin
		dx = (own_x >= ent_x) ? (own_x - ent_x) : (ent_x - own_x);
		dy = (own_y >= ent_y) ? (own_y - ent_y) : (ent_y - own_y);
	end

	// valid pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld;
		end
	end

	// squares, no reset on payload
	always_ff @(posedge clk) begin
		cand_s2 <= cand;
		idx_s2  <= idx;
		sq_x_s2 <= SQ_W'(dx) * SQ_W'(dx);
		sq_y_s2 <= SQ_W'(dy) * SQ_W'(dy);
	end

	// sum of squares
	assign dist_sum = {1'b0, sq_x_s2} + {1'b0, sq_y_s2};

endmodule

/* tb/nchs_checker.sv */
// nchs_checker: scoreboard for the nearest cluster head search core
// mirrors the node table and search limit, predicts each query answer and checks responses
// depends on nchs_pkg (beat types, request codes, register reset)

module nchs_checker #(
	parameter int NODE_COUNT = 128
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	input  logic              req_ready,
	input  nchs_pkg::req_t    req,
	input  logic              rsp_valid,
	input  logic              rsp_ready,
	input  nchs_pkg::rsp_t    rsp,
	input  logic              cfg_we,
	input  nchs_pkg::limit_t  cfg_wdata,
	output int                fail_count,
	output int                outstanding,
	output int                write_beats,
	output int                query_beats,
	output int                found_beats
);

	// shadow copy of the node table and the limit register
	nchs_pkg::coord_t node_x[NODE_COUNT];
	nchs_pkg::coord_t node_y[NODE_COUNT];
	logic             node_alive[NODE_COUNT];
	logic             node_head[NODE_COUNT];
	nchs_pkg::limit_t search_limit;

	// answers waiting for their response beat, with the node each one asked about
	nchs_pkg::rsp_t   answer_q[$];
	nchs_pkg::idx_t   asked_node_q[$];

	int               fails;
	int               writes;
	int               queries;
	int               founds;
	int               k;
	nchs_pkg::rsp_t   want;
	nchs_pkg::idx_t   asked;

	// nearest alive head strictly below the limit, lowest index on a tie
	function automatic nchs_pkg::rsp_t nearest_head(input nchs_pkg::idx_t who);
		nchs_pkg::rsp_t answer;
		int   best;
		int   dx;
		int   dy;
		int   d;
		int   j;
		answer = '0;
		best = int'(search_limit);
		if (who != 0 && int'(who) < NODE_COUNT && node_alive[who]) begin
			if (node_head[who]) begin
				// a head answers itself at distance zero
				answer.head_found = 1'b1;
				answer.head_index = who;
			end else begin
				for (j = 1; j < NODE_COUNT; j++) begin
					if (node_alive[j] && node_head[j] && j != int'(who)) begin
						dx = int'(node_x[who]) - int'(node_x[j]);
						dy = int'(node_y[who]) - int'(node_y[j]);
						d = dx * dx + dy * dy;
						if (d < best) begin
							best = d;
							answer.head_found = 1'b1;
							answer.head_index = nchs_pkg::idx_t'(j);
							answer.distance_sq = nchs_pkg::dist_t'(d);
						end
					end
				end
			end
		end
		return answer;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (k = 0; k < NODE_COUNT; k++) begin
				node_x[k] = '0;
				node_y[k] = '0;
				node_alive[k] = 1'b0;
				node_head[k] = 1'b0;
			end
			search_limit = nchs_pkg::LIMIT_RESET;
			answer_q.delete();
			asked_node_q.delete();
			fails = 0;
			writes = 0;
			queries = 0;
			founds = 0;
		end else begin
			// response beat against the oldest answer
			if (rsp_valid && rsp_ready) begin
				if (answer_q.size() == 0) begin
					fails++;
					if (fails <= 10)
						$display("unexpected response beat: found %0d head %0d dist %0d",
							rsp.head_found, rsp.head_index, rsp.distance_sq);
				end else begin
					want = answer_q.pop_front();
					asked = asked_node_q.pop_front();
					if (rsp.head_found !== want.head_found ||
							rsp.head_index !== want.head_index ||
							rsp.distance_sq !== want.distance_sq) begin
						fails++;
						if (fails <= 10)
							$display("node %0d found/head/dist: expected %0d/%0d/%0d, got %0d/%0d/%0d",
								asked, want.head_found, want.head_index, want.distance_sq,
								rsp.head_found, rsp.head_index, rsp.distance_sq);
					end
				end
			end

			// limit register write
			if (cfg_we)
				search_limit = cfg_wdata;

			// request beat: table write or query prediction
			if (req_valid && req_ready) begin
				if (req.req_type == nchs_pkg::REQ_WRITE) begin
					writes++;
					if (int'(req.node_index) < NODE_COUNT) begin
						node_x[req.node_index] = req.pos_x;
						node_y[req.node_index] = req.pos_y;
						node_alive[req.node_index] = req.alive_in;
						node_head[req.node_index] = req.head_in;
					end
				end else begin
					queries++;
					want = nearest_head(req.node_index);
					if (want.head_found)
						founds++;
					answer_q.push_back(want);
					asked_node_q.push_back(req.node_index);
				end
			end
		end
		fail_count <= fails;
		outstanding <= answer_q.size();
		write_beats <= writes;
		query_beats <= queries;
		found_beats <= founds;
	end

endmodule

/* tb/nearest_cluster_head_search_core_tb.sv */
// nearest_cluster_head_search_core_tb: stimulus and verdict for the nearest cluster head search core
// drives table writes, queries and limit settings under several idle mixes; checking is in nchs_checker
// depends on nchs_pkg, nearest_cluster_head_search_core and nchs_checker

module nearest_cluster_head_search_core_tb;

	localparam int NODE_COUNT     = 128;
	localparam int DRAIN_CYCLES   = NODE_COUNT + 16;
	localparam int WATCHDOG_LIMIT = 4000;

	logic             clk;
	logic             arst_n;
	logic             req_valid = 1'b0;
	logic             req_ready;
	nchs_pkg::req_t   req_beat = '0;
	logic             rsp_valid;
	logic             rsp_ready = 1'b0;
	nchs_pkg::rsp_t   rsp_beat;
	logic             cfg_we = 1'b0;
	nchs_pkg::limit_t cfg_wdata = '0;

	int     fail_count;
	int     outstanding;
	int     write_beats;
	int     query_beats;
	int     found_beats;
	int     send_idle_pct = 0;
	int     recv_stall_pct = 0;
	int     limit_writes = 0;
	int     stuck_cycles = 0;
	int     i;

	nearest_cluster_head_search_core #(
		.NODE_COUNT(NODE_COUNT),
		.COORD_BITS(10)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req_beat),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp_beat),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	nchs_checker #(
		.NODE_COUNT(NODE_COUNT)
	) checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req_beat),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp_beat),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.fail_count(fail_count),
		.outstanding(outstanding),
		.write_beats(write_beats),
		.query_beats(query_beats),
		.found_beats(found_beats)
	);

	// clock and reset
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
	end

	// response side stalls
	always @(posedge clk) begin
		rsp_ready <= arst_n && ($urandom_range(99) >= recv_stall_pct);
	end

	// watchdog on cycles with no beat moving
	always @(posedge clk) begin
		if (!arst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
			stuck_cycles <= 0;
		end else begin
			stuck_cycles <= stuck_cycles + 1;
			if (stuck_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no beat moved for %0d cycles", stuck_cycles);
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	function automatic nchs_pkg::req_t make_beat(input nchs_pkg::req_code_t kind, input int node,
			input int x, input int y, input bit alive, input bit head);
		nchs_pkg::req_t b;
		b.req_type = kind;
		b.node_index = nchs_pkg::idx_t'(node);
		b.pos_x = nchs_pkg::coord_t'(x);
		b.pos_y = nchs_pkg::coord_t'(y);
		b.alive_in = alive;
		b.head_in = head;
		return b;
	endfunction

	// coordinates: full range, edges, a coarse grid for ties, a tight cluster
	function automatic nchs_pkg::coord_t random_coord();
		case ($urandom_range(3))
			0: return nchs_pkg::coord_t'($urandom_range(1023));
			1: return ($urandom_range(1) != 0) ? nchs_pkg::coord_t'($urandom_range(1)) :
				nchs_pkg::coord_t'(1022 + $urandom_range(1));
			2: return nchs_pkg::coord_t'(480 + 16 * $urandom_range(4));
			default: return nchs_pkg::coord_t'(500 + $urandom_range(40));
		endcase
	endfunction

	function automatic nchs_pkg::req_t random_beat();
		nchs_pkg::req_t b;
		b.req_type = ($urandom_range(99) < 50) ? nchs_pkg::REQ_QUERY : nchs_pkg::REQ_WRITE;
		b.node_index = nchs_pkg::idx_t'($urandom_range(NODE_COUNT - 1));
		b.pos_x = random_coord();
		b.pos_y = random_coord();
		b.alive_in = ($urandom_range(99) < 85);
		b.head_in = ($urandom_range(99) < 20);
		return b;
	endfunction

	// one request beat; valid stays high into the next beat when no gap is drawn
	task automatic send_beat(input nchs_pkg::req_t b);
		int gap;
		gap = 0;
		while ($urandom_range(99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req_beat <= b;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
	endtask

	// limit write once every answer is back and the core has settled
	task automatic write_limit(input nchs_pkg::limit_t value);
		req_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		limit_writes++;
	endtask

	task automatic run_random(input int items, input int send_pct, input int stall_pct);
		send_idle_pct = send_pct;
		recv_stall_pct = stall_pct;
		repeat (items) send_beat(random_beat());
	endtask

	initial begin
		wait (arst_n === 1'b1);
		@(posedge clk);

		// give every entry known coordinates, all dead
		for (i = 0; i < NODE_COUNT; i++)
			send_beat(make_beat(nchs_pkg::REQ_WRITE, i, $urandom_range(1023),
				$urandom_range(1023), 1'b0, 1'($urandom_range(1))));

		// directed beats under the reset limit
		send_beat(make_beat(nchs_pkg::REQ_WRITE, 1, 0, 0, 1'b1, 1'b0));
		send_beat(make_beat(nchs_pkg::REQ_WRITE, 127, 1023, 1023, 1'b1, 1'b1));
		send_beat(make_beat(nchs_pkg::REQ_QUERY, 1, 0, 0, 1'b0, 1'b0));   // only head too far
		send_beat(make_beat(nchs_pkg::REQ_QUERY, 127, 1023, 1023, 1'b1, 1'b1)); // answers itself
		send_beat(make_beat(nchs_pkg::REQ_QUERY, 0, 0, 0, 1'b0, 1'b0));   // base station
		send_beat(make_beat(nchs_pkg::REQ_WRITE, 0, 1, 1, 1'b1, 1'b1));   // base station as head
		send_beat(make_beat(nchs_pkg::REQ_QUERY, 1, 0, 0, 1'b0, 1'b0));
		send_beat(make_beat(nchs_pkg::REQ_WRITE, 2, 10, 0, 1'b1, 1'b1));
		send_beat(make_beat(nchs_pkg::REQ_WRITE, 3, 0, 10, 1'b1, 1'b1));
		send_beat(make_beat(nchs_pkg::REQ_QUERY, 1, 0, 0, 1'b0, 1'b0));   // tie, lower index
		send_beat(make_beat(nchs_pkg::REQ_WRITE, 4, 5, 5, 1'b0, 1'b1));   // dead head
		send_beat(make_beat(nchs_pkg::REQ_QUERY, 1, 0, 0, 1'b0, 1'b0));
		send_beat(make_beat(nchs_pkg::REQ_WRITE, 5, 0, 0, 1'b1, 1'b1));   // same spot
		send_beat(make_beat(nchs_pkg::REQ_QUERY, 1, 0, 0, 1'b0, 1'b0));
		send_beat(make_beat(nchs_pkg::REQ_WRITE, 1, 0, 0, 1'b0, 1'b0));
		send_beat(make_beat(nchs_pkg::REQ_QUERY, 1, 0, 0, 1'b0, 1'b0));   // dead node
		send_beat(make_beat(nchs_pkg::REQ_WRITE, 6, 1023, 0, 1'b1, 1'b0));
		send_beat(make_beat(nchs_pkg::REQ_QUERY, 6, 0, 0, 1'b0, 1'b0));
		send_beat(make_beat(nchs_pkg::REQ_WRITE, 126, 23, 0, 1'b1, 1'b1)); // exactly at the limit
		send_beat(make_beat(nchs_pkg::REQ_QUERY, 6, 0, 0, 1'b0, 1'b0));
		send_beat(make_beat(nchs_pkg::REQ_WRITE, 125, 24, 0, 1'b1, 1'b1)); // just below the limit
		send_beat(make_beat(nchs_pkg::REQ_QUERY, 6, 1023, 1023, 1'b1, 1'b1));

		// random phases over limit settings and idle mixes
		write_limit(22'h3FFFFF);
		send_beat(make_beat(nchs_pkg::REQ_QUERY, 6, 0, 0, 1'b0, 1'b0));
		run_random(220, 0, 0);
		write_limit('0);
		run_random(100, 59, 0);
		write_limit(nchs_pkg::limit_t'(2093058));
		run_random(220, 0, 59);
		write_limit(nchs_pkg::limit_t'($urandom_range(1000, 300000)));
		run_random(220, 27, 27);
		write_limit(nchs_pkg::LIMIT_RESET);
		run_random(220, 59, 59);
		write_limit(nchs_pkg::limit_t'($urandom_range(1, 2000)));
		run_random(150, 0, 0);

		// drain
		req_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d table writes and %0d queries, %0d answered with a head",
			write_beats, query_beats, found_beats);
		$display("search limit rewritten %0d times, from zero to full scale", limit_writes);
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

/* sim.f */
hdl/nchs_pkg.sv
hdl/nchs_dist.sv
hdl/nearest_cluster_head_search_core.sv
tb/nchs_checker.sv
tb/nearest_cluster_head_search_core_tb.sv
